>>> hdl/abrmu_pkg.sv
//------------------------------------------------------------------------------
// abrmu_pkg
// Types, codes and constants shared by the banked register mode unit.
//------------------------------------------------------------------------------
package abrmu_pkg;

   localparam int QueueDepth = 2;

   typedef enum logic [3:0] {
      FUNC_RD        = 4'd0,
      FUNC_RD_PC4    = 4'd1,
      FUNC_RD_PC8    = 4'd2,
      FUNC_WR        = 4'd3,
      FUNC_WR_PC     = 4'd4,
      FUNC_WR_BX     = 4'd5,
      FUNC_RD_CPSR   = 4'd6,
      FUNC_WR_CPSR   = 4'd7,
      FUNC_MSR       = 4'd8,
      FUNC_RD_SPSR   = 4'd9,
      FUNC_WR_SPSR   = 4'd10,
      FUNC_EXCEPTION = 4'd11,
      FUNC_RD_FLAGS  = 4'd12,
      FUNC_WR_FLAGS  = 4'd13,
      FUNC_NOP_14    = 4'd14,
      FUNC_NOP_15    = 4'd15
   } func_type;

   typedef enum logic [2:0] {
      ERR_OK       = 3'd0,
      ERR_PC       = 3'd1,
      ERR_MODE     = 3'd2,
      ERR_JAZELLE  = 3'd3,
      ERR_THUMB    = 3'd4,
      ERR_NO_SPSR  = 3'd5,
      ERR_UNUSED_6 = 3'd6,
      ERR_UNUSED_7 = 3'd7
   } err_type;

   localparam logic [4:0] PM_USER       = 5'h10;
   localparam logic [4:0] PM_FIQ        = 5'h11;
   localparam logic [4:0] PM_IRQ        = 5'h12;
   localparam logic [4:0] PM_SUPERVISOR = 5'h13;
   localparam logic [4:0] PM_ABORT      = 5'h17;
   localparam logic [4:0] PM_UNDEFINED  = 5'h1B;
   localparam logic [4:0] PM_SYSTEM     = 5'h1F;

   localparam logic [2:0] NO_BANK = 3'd6;

   localparam logic [31:0] STATUS_KEEP   = 32'h0900_00FF;
   localparam logic [31:0] USER_MSR_DROP = 32'h0100_00FF;
   localparam logic [31:0] HIGH_VEC_BASE = 32'hFFFF_0000;
   localparam logic [31:0] STATUS_RESET  = 32'h0000_00D3;

   typedef struct packed {
      logic [3:0]  func;
      logic [3:0]  reg_index;
      logic [31:0] value;
      logic [31:0] mask;
      logic [2:0]  exception_type;
      logic        irq_request;
      logic        fiq_request;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_pending;
      logic        fiq_pending;
      logic        flush_access_cache;
      logic [2:0]  error_code;
   } rsp_type;

   // classified operation handed from front to back
   typedef struct packed {
      func_type    func;
      logic [3:0]  reg_index;
      logic        is_pc;
      logic [31:0] value;
      logic [31:0] mask;
      logic [2:0]  exception_type;
      logic        irq_request;
      logic        fiq_request;
   } op_type;

   function automatic logic [2:0] mode_bank(input logic [4:0] m);
      case (m)
         PM_USER, PM_SYSTEM: mode_bank = 3'd0;
         PM_FIQ:             mode_bank = 3'd1;
         PM_IRQ:             mode_bank = 3'd2;
         PM_SUPERVISOR:      mode_bank = 3'd3;
         PM_ABORT:           mode_bank = 3'd4;
         PM_UNDEFINED:       mode_bank = 3'd5;
         default:            mode_bank = NO_BANK;
      endcase
   endfunction

   function automatic logic [2:0] spsr_slot(input logic [4:0] m);
      case (m)
         PM_FIQ:        spsr_slot = 3'd0;
         PM_IRQ:        spsr_slot = 3'd1;
         PM_SUPERVISOR: spsr_slot = 3'd2;
         PM_ABORT:      spsr_slot = 3'd3;
         PM_UNDEFINED:  spsr_slot = 3'd4;
         default:       spsr_slot = NO_BANK;
      endcase
   endfunction

   function automatic logic [7:0] exc_mode_bits(input logic [2:0] et);
      case (et)
         3'd0:    exc_mode_bits = 8'hD3;
         3'd1:    exc_mode_bits = 8'h9B;
         3'd2:    exc_mode_bits = 8'h93;
         3'd3:    exc_mode_bits = 8'h97;
         3'd4:    exc_mode_bits = 8'h97;
         3'd6:    exc_mode_bits = 8'h92;
         3'd7:    exc_mode_bits = 8'hD1;
         default: exc_mode_bits = 8'h00;
      endcase
   endfunction

endpackage

>>> hdl/abrmu_front.sv
//------------------------------------------------------------------------------
// abrmu_front
// Accepts requests, classifies them and queues them for the execute stage.
//------------------------------------------------------------------------------
module abrmu_front import abrmu_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    op_valid,
   input  logic    op_ready,
   output op_type  op_data
);
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

   op_type            queue_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]     count_ff, count_in;
   op_type            op_new;
   logic              push, pop;

   always_comb begin
      op_new.func           = func_type'(req_data.func);
      op_new.reg_index      = req_data.reg_index;
      op_new.is_pc          = (req_data.reg_index == 4'd15);
      op_new.value          = req_data.value;
      op_new.mask           = req_data.mask;
      op_new.exception_type = req_data.exception_type;
      op_new.irq_request    = req_data.irq_request;
      op_new.fiq_request    = req_data.fiq_request;
   end

   assign req_ready = (count_ff != (PtrW+1)'(Depth));
   assign push      = req_valid && req_ready;
   assign op_valid  = (count_ff != '0);
   assign pop       = op_valid && op_ready;
   assign op_data   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

>>> hdl/abrmu_back.sv
//------------------------------------------------------------------------------
// abrmu_back
// Runs one op per cycle unless stalled, on the banked register file and status.
//------------------------------------------------------------------------------
module abrmu_back import abrmu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    high_vectors,
   input  logic    op_valid,
   output logic    op_ready,
   input  op_type  op_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic [31:0] cur_ff   [16];
   logic [31:0] cur_in   [16];
   logic [31:0] usr_ff   [5];
   logic [31:0] usr_in   [5];
   logic [31:0] fiqr_ff  [5];
   logic [31:0] fiqr_in  [5];
   logic [31:0] bank_ff  [12];
   logic [31:0] bank_in  [12];
   logic [31:0] spsr_ff  [5];
   logic [31:0] spsr_in  [5];
   logic [3:0]  nzcv_ff, nzcv_in;
   logic [31:0] stat_ff, stat_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        fire;
   logic [4:0]  om, nm;
   logic [2:0]  slot, ob, nb, nslot;
   logic [31:0] full, cand, merged, eff_mask;
   logic        do_cpsr, mode_chg;
   err_type     err, cerr;
   logic [31:0] rd;
   logic        flush;

   assign op_ready  = !rsp_valid_ff || rsp_ready;
   assign fire      = op_valid && op_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      cur_in  = cur_ff;
      usr_in  = usr_ff;
      fiqr_in = fiqr_ff;
      bank_in = bank_ff;
      spsr_in = spsr_ff;
      nzcv_in = nzcv_ff;
      stat_in = stat_ff;
      rd      = '0;
      err     = ERR_OK;
      cerr    = ERR_OK;
      flush   = 1'b0;
      do_cpsr = 1'b0;
      nslot   = NO_BANK;
      full    = {nzcv_ff, stat_ff[27:0]};
      om      = stat_ff[4:0];
      slot    = spsr_slot(om);
      cand    = op_data.value;
      eff_mask = op_data.mask;
      if ((stat_ff & 32'h0F) == 32'h0) begin
         eff_mask = op_data.mask & ~USER_MSR_DROP;
      end
      merged  = (op_data.value & eff_mask) | (full & ~eff_mask);

      case (op_data.func)
         FUNC_RD: begin
            if (op_data.is_pc) err = ERR_PC;
            else rd = cur_ff[op_data.reg_index];
         end
         FUNC_RD_PC4: rd = cur_ff[op_data.reg_index] + (op_data.is_pc ? 32'd4 : 32'd0);
         FUNC_RD_PC8: rd = cur_ff[op_data.reg_index] + (op_data.is_pc ? 32'd8 : 32'd0);
         FUNC_WR: begin
            if (op_data.is_pc) err = ERR_PC;
            else cur_in[op_data.reg_index] = op_data.value;
         end
         FUNC_WR_PC: cur_in[op_data.reg_index] = op_data.value;
         FUNC_WR_BX: begin
            cur_in[op_data.reg_index] = op_data.value;
            if (op_data.is_pc && op_data.value[0]) begin
               stat_in[5] = 1'b1;
               cur_in[15] = {op_data.value[31:1], 1'b0};
            end
         end
         FUNC_RD_CPSR: rd = full;
         FUNC_WR_CPSR: do_cpsr = 1'b1;
         FUNC_MSR: begin
            cand = merged;
            if (merged[5]) err = ERR_THUMB;
            else do_cpsr = 1'b1;
         end
         FUNC_RD_SPSR: begin
            if (slot == NO_BANK) err = ERR_NO_SPSR;
            else rd = spsr_ff[slot];
         end
         FUNC_WR_SPSR: begin
            if (slot == NO_BANK) err = ERR_NO_SPSR;
            else spsr_in[slot] = (spsr_ff[slot] & ~op_data.mask) | (op_data.value & op_data.mask);
         end
         FUNC_EXCEPTION: begin
            cand = {full[31:8], 2'b00, full[5:0]} & ~32'h3F;
            cand[7:0] = {full[7:6], 6'b0} | exc_mode_bits(op_data.exception_type);
            do_cpsr = 1'b1;
         end
         FUNC_RD_FLAGS: rd = {nzcv_ff, 28'h0};
         FUNC_WR_FLAGS: nzcv_in = op_data.value[31:28];
         default: ;
      endcase

      // full status write with bank swap
      nm       = cand[4:0];
      mode_chg = (om != nm);
      ob       = mode_bank(om);
      nb       = mode_bank(nm);
      if (do_cpsr) begin
         if (mode_chg && nb == NO_BANK) cerr = ERR_MODE;
         else if (cand[24]) cerr = ERR_JAZELLE;
         err = cerr;
         if (cerr == ERR_OK) begin
            if (mode_chg) begin
               for (int k = 0; k < 5; k++) begin
                  if (om == PM_FIQ) fiqr_in[k] = cur_ff[8+k];
                  else usr_in[k] = cur_ff[8+k];
               end
               if (ob != NO_BANK) begin
                  bank_in[{ob, 1'b0}] = cur_ff[13];
                  bank_in[{ob, 1'b1}] = cur_ff[14];
               end
               for (int k = 0; k < 5; k++) begin
                  cur_in[8+k] = (nm == PM_FIQ) ? fiqr_in[k] : usr_in[k];
               end
               cur_in[13] = bank_in[{nb, 1'b0}];
               cur_in[14] = bank_in[{nb, 1'b1}];
               flush = (om == PM_USER) != (nm == PM_USER);
            end
            nzcv_in = cand[31:28];
            stat_in = cand & STATUS_KEEP;
            if (op_data.func == FUNC_EXCEPTION) begin
               nslot = spsr_slot(nm);
               if (nslot != NO_BANK) spsr_in[nslot] = full;
               cur_in[14] = cur_ff[15];
               cur_in[15] = {27'h0, op_data.exception_type, 2'b00}
                          + (high_vectors ? HIGH_VEC_BASE : 32'h0);
            end
         end
      end
      if (err != ERR_OK) begin
         rd = '0;
      end
      rsp_in.read_data          = rd;
      rsp_in.irq_pending        = op_data.irq_request && !stat_in[7];
      rsp_in.fiq_pending        = op_data.fiq_request && !stat_in[6];
      rsp_in.flush_access_cache = flush;
      rsp_in.error_code         = err;
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) cur_ff[k] <= '0;
         for (int k = 0; k < 5; k++) begin
            usr_ff[k]  <= '0;
            fiqr_ff[k] <= '0;
            spsr_ff[k] <= '0;
         end
         for (int k = 0; k < 12; k++) bank_ff[k] <= '0;
         nzcv_ff      <= '0;
         stat_ff      <= STATUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            cur_ff  <= cur_in;
            usr_ff  <= usr_in;
            fiqr_ff <= fiqr_in;
            bank_ff <= bank_in;
            spsr_ff <= spsr_in;
            nzcv_ff <= nzcv_in;
            stat_ff <= stat_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> hdl/arm_banked_register_mode_unit.sv
//------------------------------------------------------------------------------
// arm_banked_register_mode_unit
// ARMv5 register file with mode banking, CPSR/SPSR and exception entry.
//------------------------------------------------------------------------------
// channel | direction | payload
// req     | in        | req_type: func, reg_index, value, mask, exception_type
// rsp     | out       | rsp_type: read_data, pending bits, flush, error_code
// csr     | in        | high_vectors
//
// One request per cycle while the queue has room; each response is formed
// through the queue, then the execute register. The execute stage does the
// whole bank swap in the same update as the status write. Synchronous reset
// puts the core in supervisor mode with interrupts masked. A stalled response
// holds the execute stage; the queue absorbs up to Depth requests.
//------------------------------------------------------------------------------
module arm_banked_register_mode_unit import abrmu_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);
   logic   high_vectors_ff;
   logic   op_valid, op_ready;
   op_type op_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_vectors_ff <= 1'b0;
      end else if (csr_valid) begin
         high_vectors_ff <= csr_data;
      end
   end

   abrmu_front #(.Depth(Depth)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .op_valid, .op_ready, .op_data
   );

   abrmu_back u_back (
      .clock, .reset, .high_vectors(high_vectors_ff),
      .op_valid, .op_ready, .op_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_OK |-> rsp_data.read_data == 32'h0)
      else $error("error response carries data");

   a_err_no_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_OK |-> !rsp_data.flush_access_cache)
      else $error("flush on failed operation");

endmodule
